@@ rtl/rhm_pkg.sv @@
`default_nettype none

package rhm_pkg;

   localparam int PIXEL_LEVELS = 256;
   localparam int MAX_SIDE     = 15;
   localparam int PIX_W        = 8;
   localparam int CNT_W        = 8;
   localparam int SIDE_W       = 4;

   localparam logic [PIX_W-1:0]  TOP_LEVEL   = PIX_W'(PIXEL_LEVELS - 1);
   localparam logic [CNT_W-1:0]  MAX_SAMPLES = CNT_W'(MAX_SIDE * MAX_SIDE);
   localparam logic [SIDE_W-1:0] RESET_SIDE  = SIDE_W'(7);

   typedef enum logic [1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_INSERT = 2'd1,
      FUNC_SWAP   = 2'd2
   } func_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_CAPTURE,
      OP_CLEAR,
      OP_DROP_RD,
      OP_DROP_WR,
      OP_ADD_RD,
      OP_ADD_WR,
      OP_WALK_START,
      OP_WALK_UP,
      OP_WALK_DN,
      OP_EMIT
   } dp_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_CLEAR,
      ST_DROP_RD,
      ST_DROP_WR,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_WALK_START,
      ST_WALK_UP,
      ST_WALK_DN,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      func_type func;
      logic     total_zero;
      logic     below_gt_th;
      logic     up_go;
      logic     dn_go;
      logic     out_free;
   } dp_status_type;

endpackage

`default_nettype wire

@@ rtl/rhm_bin_store.sv @@
`default_nettype none

module rhm_bin_store (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      clear,
   input  wire logic                      wr_en,
   input  wire logic [rhm_pkg::PIX_W-1:0] wr_addr,
   input  wire logic [rhm_pkg::CNT_W-1:0] wr_data,
   input  wire logic [rhm_pkg::PIX_W-1:0] rd_addr,
   output logic      [rhm_pkg::CNT_W-1:0] rd_count
);
   import rhm_pkg::*;

   logic [CNT_W-1:0]        mem_bins [PIXEL_LEVELS];
   logic [PIXEL_LEVELS-1:0] valid_ff;
   logic [PIXEL_LEVELS-1:0] valid_in;
   logic [CNT_W-1:0]        rd_data_ff;
   logic                    rd_hit_ff;

   // a bin never written since the last clear reads as empty
   always_comb begin
      valid_in = valid_ff;
      if (clear) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_bins[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_bins[rd_addr];
      rd_hit_ff  <= valid_ff[rd_addr];
   end

   assign rd_count = rd_hit_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

@@ rtl/rhm_ctrl.sv @@
`default_nettype none

module rhm_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire rhm_pkg::dp_status_type status,
   output rhm_pkg::dp_cmd_type         cmd
);
   import rhm_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            case (status.func)
               FUNC_CLEAR:  state_in = ST_CLEAR;
               FUNC_INSERT: state_in = ST_ADD_RD;
               FUNC_SWAP:   state_in = ST_DROP_RD;
               default:     state_in = ST_DONE;
            endcase
         end
         ST_CLEAR:   state_in = ST_WALK_START;
         ST_DROP_RD: state_in = ST_DROP_WR;
         ST_DROP_WR: state_in = ST_ADD_RD;
         ST_ADD_RD:  state_in = ST_ADD_WR;
         ST_ADD_WR:  state_in = ST_WALK_START;
         ST_WALK_START: begin
            if (status.total_zero) begin
               state_in = ST_DONE;
            end else if (status.below_gt_th) begin
               state_in = ST_WALK_DN;
            end else begin
               state_in = ST_WALK_UP;
            end
         end
         ST_WALK_UP: begin
            if (!status.up_go) state_in = ST_DONE;
         end
         ST_WALK_DN: begin
            if (!status.dn_go) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd.op     = OP_IDLE;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.op = OP_CAPTURE;
         end
         ST_CLEAR:      cmd.op = OP_CLEAR;
         ST_DROP_RD:    cmd.op = OP_DROP_RD;
         ST_DROP_WR:    cmd.op = OP_DROP_WR;
         ST_ADD_RD:     cmd.op = OP_ADD_RD;
         ST_ADD_WR:     cmd.op = OP_ADD_WR;
         ST_WALK_START: cmd.op = OP_WALK_START;
         ST_WALK_UP:    cmd.op = OP_WALK_UP;
         ST_WALK_DN:    cmd.op = OP_WALK_DN;
         ST_DONE: begin
            if (status.out_free) cmd.op = OP_EMIT;
         end
         default: cmd.op = OP_IDLE;
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/rhm_dp.sv @@
`default_nettype none

module rhm_dp (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire rhm_pkg::dp_cmd_type        cmd,
   output rhm_pkg::dp_status_type          status,
   input  wire logic [1:0]                 req_func,
   input  wire logic [rhm_pkg::PIX_W-1:0]  req_old_pixel,
   input  wire logic [rhm_pkg::PIX_W-1:0]  req_new_pixel,
   input  wire logic                       csr_wr_en,
   input  wire logic [rhm_pkg::SIDE_W-1:0] csr_wr_data,
   input  wire logic                       rsp_tready,
   output logic                            rsp_tvalid,
   output logic      [rhm_pkg::PIX_W-1:0]  rsp_median,
   output logic      [rhm_pkg::CNT_W-1:0]  rsp_below_count
);
   import rhm_pkg::*;

   logic [SIDE_W-1:0] side_ff;
   logic [SIDE_W-1:0] side_in;
   func_type          func_ff;
   func_type          func_in;
   logic [PIX_W-1:0]  old_ff;
   logic [PIX_W-1:0]  old_in;
   logic [PIX_W-1:0]  new_ff;
   logic [PIX_W-1:0]  new_in;
   logic [PIX_W-1:0]  med_ff;
   logic [PIX_W-1:0]  med_in;
   logic [CNT_W-1:0]  below_ff;
   logic [CNT_W-1:0]  below_in;
   logic [CNT_W-1:0]  total_ff;
   logic [CNT_W-1:0]  total_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [PIX_W-1:0]  rsp_med_ff;
   logic [CNT_W-1:0]  rsp_below_ff;

   logic [2*SIDE_W-1:0] side_sq;
   logic [CNT_W-1:0]    th;
   logic [CNT_W:0]      up_sum;
   logic [CNT_W-1:0]    cnt;
   logic                below_gt_th;
   logic                store_clear;
   logic                wr_en;
   logic [PIX_W-1:0]    wr_addr;
   logic [CNT_W-1:0]    wr_data;
   logic [PIX_W-1:0]    rd_addr;

   rhm_bin_store u_bins (
      .clock    (clock),
      .reset    (reset),
      .clear    (store_clear),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr),
      .rd_count (cnt)
   );

   // median threshold is side*side/2
   assign side_sq     = {{SIDE_W{1'b0}}, side_ff} * {{SIDE_W{1'b0}}, side_ff};
   assign th          = CNT_W'(side_sq >> 1);
   assign below_gt_th = below_ff > th;
   assign up_sum      = {1'b0, below_ff} + {1'b0, cnt};

   assign status.func        = func_ff;
   assign status.total_zero  = (total_ff == '0);
   assign status.below_gt_th = below_gt_th;
   assign status.up_go       = (med_ff != TOP_LEVEL) && (up_sum <= {1'b0, th});
   assign status.dn_go       = below_gt_th && (med_ff != '0);
   assign status.out_free    = !rsp_valid_ff || rsp_tready;

   assign store_clear = (cmd.op == OP_CLEAR);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = new_ff;
      wr_data = cnt + CNT_W'(1);
      if (cmd.op == OP_DROP_WR) begin
         wr_en   = (cnt != '0);
         wr_addr = old_ff;
         wr_data = cnt - CNT_W'(1);
      end else if (cmd.op == OP_ADD_WR) begin
         wr_en = (total_ff < MAX_SAMPLES);
      end
   end

   // the walk reads one bin ahead, so the next bin's count is ready for each step
   always_comb begin
      case (cmd.op)
         OP_DROP_RD:    rd_addr = old_ff;
         OP_ADD_RD:     rd_addr = new_ff;
         OP_WALK_START: rd_addr = below_gt_th ? med_ff - PIX_W'(1) : med_ff;
         OP_WALK_UP:    rd_addr = med_ff + PIX_W'(1);
         OP_WALK_DN:    rd_addr = med_ff - PIX_W'(2);
         default:       rd_addr = med_ff;
      endcase
   end

   always_comb begin
      side_in      = csr_wr_en ? csr_wr_data : side_ff;
      func_in      = func_ff;
      old_in       = old_ff;
      new_in       = new_ff;
      med_in       = med_ff;
      below_in     = below_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (cmd.op)
         OP_CAPTURE: begin
            func_in = func_type'(req_func);
            old_in  = req_old_pixel;
            new_in  = req_new_pixel;
         end
         OP_CLEAR: begin
            med_in   = '0;
            below_in = '0;
            total_in = '0;
         end
         OP_DROP_WR: begin
            if (cnt != '0) begin
               total_in = total_ff - CNT_W'(1);
               if (old_ff < med_ff) below_in = below_ff - CNT_W'(1);
            end
         end
         OP_ADD_WR: begin
            if (total_ff < MAX_SAMPLES) begin
               total_in = total_ff + CNT_W'(1);
               if (new_ff < med_ff) below_in = below_ff + CNT_W'(1);
            end
         end
         OP_WALK_START: begin
            // empty window: every bin is zero, the walk ends at the top level
            if (total_ff == '0) begin
               med_in   = TOP_LEVEL;
               below_in = '0;
            end
         end
         OP_WALK_UP: begin
            if (status.up_go) begin
               med_in   = med_ff + PIX_W'(1);
               below_in = up_sum[CNT_W-1:0];
            end
         end
         OP_WALK_DN: begin
            if (status.dn_go) begin
               med_in   = med_ff - PIX_W'(1);
               below_in = below_ff - cnt;
            end
         end
         OP_EMIT: rsp_valid_in = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff      <= RESET_SIDE;
         med_ff       <= '0;
         below_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         side_ff      <= side_in;
         med_ff       <= med_in;
         below_ff     <= below_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      old_ff  <= old_in;
      new_ff  <= new_in;
      if (cmd.op == OP_EMIT) begin
         rsp_med_ff   <= med_ff;
         rsp_below_ff <= below_ff;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_median      = rsp_med_ff;
   assign rsp_below_count = rsp_below_ff;

endmodule

`default_nettype wire

@@ rtl/running_histogram_median_unit.sv @@
// Running-histogram median engine for 8-bit samples. Each request transaction
// carries a command in req_tuser (clear window, insert new sample, or swap:
// remove old sample then insert new) and yields one response transaction with
// the median of the window and the number of samples strictly below it. The
// median is tracked incrementally: after the histogram update it walks one
// bin per cycle until below <= side*side/2 < below + bin[median]; it stops at
// level 255 going up and at level 0 going down, one read of the 256-entry
// histogram memory per step. Insert reads and writes the new sample's bin,
// swap first the old sample's bin; clear empties the window (median 255);
// an unused command only answers. A pending response holds back the next.
// Absent removals and inserts into a full 15x15 window are ignored. The
// user writes window_side through csr_wr_en and csr_wr_data only while no
// transaction is in flight; the block does not enforce it. It resets to 7.
`default_nettype none

module running_histogram_median_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [15:0]                req_tdata,  // old_pixel[7:0], new_pixel[15:8]
   input  wire logic [1:0]                 req_tuser,  // func[1:0]
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic      [15:0]                rsp_tdata,  // median[7:0], below_count[15:8]
   input  wire logic                       csr_wr_en,
   input  wire logic [rhm_pkg::SIDE_W-1:0] csr_wr_data // window_side
);
   import rhm_pkg::*;

   dp_cmd_type       cmd;
   dp_status_type    status;
   logic [PIX_W-1:0] median;
   logic [CNT_W-1:0] below_count;

   rhm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rhm_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_func        (req_tuser),
      .req_old_pixel   (req_tdata[7:0]),
      .req_new_pixel   (req_tdata[15:8]),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_median      (median),
      .rsp_below_count (below_count)
   );

   assign rsp_tdata = {below_count, median};

endmodule

`default_nettype wire

@@ tb/running_histogram_median_unit_tb.sv @@
`timescale 1ns / 100ps

module running_histogram_median_unit_tb;
   import rhm_pkg::*;

   localparam int CLK_HALF = 4;
   localparam int RESET_CYCLES = 6;
   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int REPORT_MAX = 10;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int HOLD_OFF_AFTER = 120;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [15:0]         req_tdata = '0;   // old_pixel[7:0], new_pixel[15:8]
   logic [1:0]          req_tuser = '0;   // func[1:0]
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [15:0]         rsp_tdata;        // median[7:0], below_count[15:8]
   logic                csr_wr_en = 1'b0;
   logic [SIDE_W-1:0]   csr_wr_data = RESET_SIDE;

   typedef struct packed {
      logic [PIX_W-1:0] median;
      logic [CNT_W-1:0] below_count;
   } median_result_type;

   class window_median_predictor;
      logic [CNT_W-1:0]  hist [PIXEL_LEVELS];
      logic [PIX_W-1:0]  med;
      int unsigned       below;
      int unsigned       total;
      logic [SIDE_W-1:0] side;
      median_result_type pending_medians[$];
      int                errors;

      function new();
         clear_window();
         side = RESET_SIDE;
         errors = 0;
      endfunction

      function void clear_window();
         foreach (hist[i]) hist[i] = '0;
         med = '0;
         below = 0;
         total = 0;
      endfunction

      function void set_side(logic [SIDE_W-1:0] s);
         side = s;
      endfunction

      function void drop_pixel(logic [PIX_W-1:0] g);
         if (hist[g] == 0) return;
         hist[g]--;
         total--;
         if (g < med) below--;
      endfunction

      function void add_pixel(logic [PIX_W-1:0] g);
         if (total >= MAX_SAMPLES) return;
         hist[g]++;
         total++;
         if (g < med) below++;
      endfunction

      function void walk_median();
         int unsigned s;
         int unsigned th;
         s = (side > MAX_SIDE) ? MAX_SIDE : side;
         th = (s * s) / 2;
         if (below > th) begin
            while (below > th && med > 0) begin
               med--;
               below -= hist[med];
            end
         end else begin
            while (med < TOP_LEVEL && below + hist[med] <= th) begin
               below += hist[med];
               med++;
            end
         end
      endfunction

      function void note_request(logic [1:0] func, logic [PIX_W-1:0] oldp,
                                 logic [PIX_W-1:0] newp);
         median_result_type r;
         case (func)
            FUNC_CLEAR: begin
               clear_window();
               walk_median();
            end
            FUNC_INSERT: begin
               add_pixel(newp);
               walk_median();
            end
            FUNC_SWAP: begin
               drop_pixel(oldp);
               add_pixel(newp);
               walk_median();
            end
            default: ;  // unused code leaves the window as it is
         endcase
         r.median = med;
         r.below_count = below[CNT_W-1:0];
         pending_medians = {pending_medians, r};
      endfunction

      function void flag_mismatch(string field, int exp_val, int got_val);
         errors++;
         if (errors <= REPORT_MAX)
            $display("mismatch on %s: expected %0d, got %0d", field, exp_val, got_val);
      endfunction

      function void check_response(logic [15:0] data);
         median_result_type exp_r;
         if (pending_medians.size() == 0) begin
            errors++;
            if (errors <= REPORT_MAX)
               $display("response with nothing pending: median %0d below %0d",
                        data[7:0], data[15:8]);
            return;
         end
         exp_r = pending_medians.pop_front();
         if (data[7:0] !== exp_r.median)
            flag_mismatch("median", exp_r.median, data[7:0]);
         if (data[15:8] !== exp_r.below_count)
            flag_mismatch("below_count", exp_r.below_count, data[15:8]);
      endfunction

      function int pending();
         return pending_medians.size();
      endfunction
   endclass

   window_median_predictor sb;
   int n_accepted = 0;
   int cycle_count;

   running_histogram_median_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // mostly near the local level, like image data, with some spread and extremes
   function automatic logic [PIX_W-1:0] pick_pixel(logic [PIX_W-1:0] center);
      int r;
      int v;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         v = int'(center) + $urandom_range(0, 16) - 8;
         if (v < 0) v = 0;
         if (v > PIXEL_LEVELS - 1) v = PIXEL_LEVELS - 1;
         return PIX_W'(v);
      end
      if (r < 85) return PIX_W'($urandom);
      return ($urandom_range(0, 1) == 1) ? TOP_LEVEL : '0;
   endfunction

   task automatic send_item(input logic [1:0] func, input logic [PIX_W-1:0] oldp,
                            input logic [PIX_W-1:0] newp);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {newp, oldp};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(func, oldp, newp);
      n_accepted++;
   endtask

   task automatic write_side(input logic [SIDE_W-1:0] s);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= s;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_side(s);
   endtask

   // fill the window to side*side (8 for side 0), then slide it with swaps of real members,
   // mixed with stray inserts, swaps of absent samples, unused codes and clears
   task automatic run_phase(input logic [SIDE_W-1:0] s, input int swaps);
      logic [PIX_W-1:0] win_q[$];
      logic [PIX_W-1:0] center;
      logic [PIX_W-1:0] oldp;
      logic [PIX_W-1:0] newp;
      int fill_target;
      int idx;
      int r;
      write_side(s);
      fill_target = (s == 0) ? 8 : int'(s) * int'(s);
      center = PIX_W'($urandom);
      send_item(FUNC_CLEAR, PIX_W'($urandom), PIX_W'($urandom));
      for (int i = 0; i < fill_target; i++) begin
         newp = pick_pixel(center);
         send_item(FUNC_INSERT, PIX_W'($urandom), newp);
         win_q = {win_q, newp};
      end
      if (fill_target == int'(MAX_SAMPLES)) begin
         // window full: these inserts are dropped
         repeat (4) send_item(FUNC_INSERT, PIX_W'($urandom), pick_pixel(center));
      end
      for (int i = 0; i < swaps; i++) begin
         if ($urandom_range(0, 9) == 0) center = PIX_W'($urandom);
         newp = pick_pixel(center);
         r = $urandom_range(0, 99);
         if (r < 75) begin
            if (win_q.size() < fill_target) begin
               send_item(FUNC_INSERT, PIX_W'($urandom), newp);
               win_q = {win_q, newp};
            end else begin
               idx = $urandom_range(0, win_q.size() - 1);
               oldp = win_q[idx];
               win_q[idx] = newp;
               send_item(FUNC_SWAP, oldp, newp);
            end
         end else if (r < 83) begin
            send_item(FUNC_INSERT, PIX_W'($urandom), newp);
            if (win_q.size() < int'(MAX_SAMPLES)) win_q = {win_q, newp};
         end else if (r < 89) begin
            send_item(FUNC_SWAP, PIX_W'($urandom), newp);
         end else if (r < 95 || fill_target > 49) begin
            send_item(FUNC_UNUSED, PIX_W'($urandom), PIX_W'($urandom));
         end else begin
            send_item(FUNC_CLEAR, PIX_W'($urandom), PIX_W'($urandom));
            win_q.delete();
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
         sb.check_response(rsp_tdata);
   end

   // response side: random stalls, plus one long hold-off while requests keep coming
   initial begin
      logic rdy;
      int len;
      int r;
      bit hold_done;
      hold_done = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && n_accepted >= HOLD_OFF_AFTER) begin
            hold_done = 1;
            rdy = 1'b0;
            len = HOLD_OFF_CYCLES;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
               rdy = 1'b1;
               len = $urandom_range(1, 20);
            end else if (r < 62) begin
               rdy = 1'b1;
               len = $urandom_range(50, 100);
            end else if (r < 92) begin
               rdy = 1'b0;
               len = $urandom_range(1, 3);
            end else begin
               rdy = 1'b0;
               len = $urandom_range(10, 40);
            end
         end
         rsp_tready <= rdy;
         repeat (len) @(posedge clock);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty window, extremes, absent removal, unused code
      send_item(FUNC_CLEAR, 8'h00, 8'h00);
      send_item(FUNC_UNUSED, 8'hFF, 8'hFF);
      send_item(FUNC_SWAP, 8'h00, 8'h00);
      send_item(FUNC_INSERT, 8'h00, 8'hFF);
      send_item(FUNC_INSERT, 8'hFF, 8'hFF);
      send_item(FUNC_INSERT, 8'h00, 8'h00);
      send_item(FUNC_INSERT, 8'h00, 8'h80);
      send_item(FUNC_SWAP, 8'hFF, 8'h00);
      send_item(FUNC_SWAP, 8'h4D, 8'hFF);
      send_item(FUNC_INSERT, 8'hAA, 8'h01);
      send_item(FUNC_INSERT, 8'h55, 8'hFE);
      send_item(FUNC_UNUSED, 8'h00, 8'h00);
      send_item(FUNC_CLEAR, 8'hFF, 8'hFF);
      send_item(FUNC_INSERT, 8'hFF, 8'h80);
      send_item(FUNC_SWAP, 8'h80, 8'h80);
      send_item(FUNC_SWAP, 8'h80, 8'h7F);

      run_phase(4'd15, 60);
      run_phase(4'd1, 60);
      run_phase(4'd0, 50);
      run_phase(4'd7, 60);
      run_phase(4'd4, 60);
      run_phase(SIDE_W'($urandom_range(2, 10)), 60);
      run_phase(4'd2, 60);

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      sb.errors += sb.pending();
      if (sb.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ files.f @@
rtl/rhm_pkg.sv
rtl/rhm_bin_store.sv
rtl/rhm_ctrl.sv
rtl/rhm_dp.sv
rtl/running_histogram_median_unit.sv
tb/running_histogram_median_unit_tb.sv
